/* design/kefuf_pkg.sv */
// Shared constants for the spanning-tree edge filter.
`default_nettype none
package kefuf_pkg;

  // Fixed field widths of the stream payload and the register.
  localparam int unsigned VTX_W = 8;   // vertex index fields
  localparam int unsigned CNT_W = 8;   // taken-edge counter
  localparam int unsigned VC_W  = 9;   // vertex_count register
  localparam int unsigned RANK_W = 4;  // union-by-rank rank

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;
  localparam int unsigned VC_RESET         = 256;

endpackage
`default_nettype wire

/* design/kruskal_edge_filter_union_find.sv */
// Spanning-tree edge filter: union-find table with path compression and union by rank.
// An edge with a bad endpoint, or one that arrives with the tree already complete, goes
// straight to the result register. Otherwise the sequencer finds the root of each endpoint
// in turn and compresses its path, then joins the two roots, with a rank update when
// equal ranks are joined. One edge at a time: every step shares the single write
// port of the table memory. Reset clears the table valid bits at once; no clearing pass.
`default_nettype none
module kruskal_edge_filter_union_find
  import kefuf_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  // Configuration: vertex_count
  input  wire logic            cfg_we_i,
  input  wire logic [VC_W-1:0] cfg_wdata_i,

  // Edge stream in
  input  wire logic                                        s_axis_tvalid,
  output logic                                             s_axis_tready,
  // tdata, low to high: src_vertex, dest_vertex, edge_weight, new_graph
  input  wire logic [((2*VTX_W+WEIGHT_BITS+1+7)/8)*8-1:0]  s_axis_tdata,
  input  wire logic                                        s_axis_tlast,   // last_edge

  // Result stream out
  output logic                                             m_axis_tvalid,
  input  wire logic                                        m_axis_tready,
  // tdata, low to high: taken, tree_src, tree_dest, tree_weight, tree_count,
  //                     tree_complete, bad_vertex
  output logic [((2*VTX_W+WEIGHT_BITS+CNT_W+3+7)/8)*8-1:0] m_axis_tdata,
  output logic                                             m_axis_tlast    // end_of_graph
);

  localparam int unsigned IW  = ((2*VTX_W+WEIGHT_BITS+1+7)/8)*8;
  localparam int unsigned OW  = ((2*VTX_W+WEIGHT_BITS+CNT_W+3+7)/8)*8;
  localparam int unsigned VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = (CW > VC_W) ? CW : VC_W;
  localparam int unsigned MW  = RANK_W + VW;

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ROOT_RD  = 3'd1;
  localparam logic [2:0] S_ROOT_CHK = 3'd2;
  localparam logic [2:0] S_CMP_RD   = 3'd3;
  localparam logic [2:0] S_CMP_WR   = 3'd4;
  localparam logic [2:0] S_UNION    = 3'd5;
  localparam logic [2:0] S_RANK     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  // Input field unpacking
  logic [VTX_W-1:0]       in_src, in_dst;
  logic [WEIGHT_BITS-1:0] in_w;
  logic                   in_new;

  assign in_src = s_axis_tdata[VTX_W-1:0];
  assign in_dst = s_axis_tdata[2*VTX_W-1:VTX_W];
  assign in_w   = s_axis_tdata[2*VTX_W+WEIGHT_BITS-1:2*VTX_W];
  assign in_new = s_axis_tdata[2*VTX_W+WEIGHT_BITS];

  // Registers
  logic [VC_W-1:0]        vc_q;
  logic [2:0]             state_q;
  logic [VW-1:0]          cur_q, start_q, root_q, rx_q, ry_q;
  logic [RANK_W-1:0]      rkx_q, rky_q;
  logic                   phase_q;
  logic [VTX_W-1:0]       src_q, dst_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                   last_q, bad_q, take_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [MAX_VERTICES-1:0] vld_q;

  // Output register
  logic                   ov_q, o_take_q, o_cmp_q, o_bad_q, o_last_q;
  logic [VTX_W-1:0]       o_src_q, o_dst_q;
  logic [WEIGHT_BITS-1:0] o_w_q;
  logic [CNT_W-1:0]       o_cnt_q;

  // Table memory: {rank, parent}; an entry with its valid bit low reads as
  // parent = own index, rank = 0.
  logic [MW-1:0] mem [MAX_VERTICES];
  logic [MW-1:0] rd_q;
  logic          rd_vld_q;

  // Effective vertex count (clamped to table depth) and tree target
  logic [EW-1:0] eff, target;
  always_comb begin
    eff = (EW'(vc_q) < EW'(MAX_VERTICES)) ? EW'(vc_q) : EW'(MAX_VERTICES);
    target = (eff == '0) ? '0 : eff - EW'(1);
  end

  // Entry seen at cur_q, defaults applied for never-written entries
  logic [VW-1:0]     pe;
  logic [RANK_W-1:0] rk;
  assign pe = rd_vld_q ? rd_q[VW-1:0] : cur_q;
  assign rk = rd_vld_q ? rd_q[MW-1:VW] : '0;

  // Accept-time checks
  logic          in_bad;
  logic [CNT_W-1:0] cnt_eff;
  assign in_bad  = (EW'(in_src) >= eff) || (EW'(in_dst) >= eff);
  assign cnt_eff = in_new ? '0 : cnt_q;

  assign s_axis_tready = (state_q == S_IDLE);

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  // Single write port
  logic          we;
  logic [VW-1:0] waddr;
  logic [MW-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = {rk, root_q};
    case (state_q)
      S_CMP_WR: begin
        we = 1'b1;
      end
      S_UNION: begin
        if (rx_q != ry_q) begin
          we = 1'b1;
          if (rkx_q < rky_q) begin
            waddr = rx_q;
            wdata = {rkx_q, ry_q};
          end else begin
            waddr = ry_q;
            wdata = {rky_q, rx_q};
          end
        end
      end
      S_RANK: begin
        we    = 1'b1;
        waddr = rx_q;
        wdata = {(rkx_q < RANK_MAX) ? rkx_q + RANK_W'(1) : rkx_q, rx_q};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[cur_q];
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_W'(VC_RESET);
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  // Sequencer and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      cnt_q    <= '0;
      phase_q  <= 1'b0;
      take_q   <= 1'b0;
      bad_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[cur_q];
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      // Drop the result after its transfer unless S_DONE loads the next one
      if (ov_q && m_axis_tready && (state_q != S_DONE)) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (acc) begin
            // A new graph drops every table entry back to its reset value
            if (in_new) begin
              vld_q <= '0;
              cnt_q <= '0;
            end
            bad_q   <= in_bad;
            take_q  <= 1'b0;
            phase_q <= 1'b0;
            cur_q   <= VW'(in_src);
            start_q <= VW'(in_src);
            if (in_bad || (EW'(cnt_eff) >= target)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_ROOT_RD;
            end
          end
        end
        S_ROOT_RD: begin
          state_q <= S_ROOT_CHK;
        end
        S_ROOT_CHK: begin
          if (pe == cur_q) begin
            // Root found: record it, then walk the path again to compress it
            root_q <= cur_q;
            if (!phase_q) begin
              rx_q  <= cur_q;
              rkx_q <= rk;
            end else begin
              ry_q  <= cur_q;
              rky_q <= rk;
            end
            cur_q   <= start_q;
            state_q <= S_CMP_RD;
          end else begin
            cur_q   <= pe;
            state_q <= S_ROOT_RD;
          end
        end
        S_CMP_RD: begin
          if (cur_q == root_q) begin
            if (!phase_q) begin
              phase_q <= 1'b1;
              cur_q   <= VW'(dst_q);
              start_q <= VW'(dst_q);
              state_q <= S_ROOT_RD;
            end else begin
              state_q <= S_UNION;
            end
          end else begin
            state_q <= S_CMP_WR;
          end
        end
        S_CMP_WR: begin
          // Point this vertex at the root, advance to its old parent
          cur_q   <= pe;
          state_q <= S_CMP_RD;
        end
        S_UNION: begin
          if (rx_q != ry_q) begin
            take_q <= 1'b1;
            cnt_q  <= cnt_q + CNT_W'(1);
            if (rkx_q == rky_q) begin
              state_q <= S_RANK;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RANK: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Edge payload capture and output payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      src_q  <= in_src;
      dst_q  <= in_dst;
      w_q    <= in_w;
      last_q <= s_axis_tlast;
    end
    if ((state_q == S_DONE) && out_free) begin
      o_take_q <= take_q;
      o_src_q  <= src_q;
      o_dst_q  <= dst_q;
      o_w_q    <= w_q;
      o_cnt_q  <= cnt_q;
      o_cmp_q  <= (EW'(cnt_q) >= target);
      o_bad_q  <= bad_q;
      o_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = OW'({o_bad_q, o_cmp_q, o_cnt_q, o_w_q, o_dst_q, o_src_q, o_take_q});

  // IW only sizes the input port
  logic unused_in;
  assign unused_in = ^s_axis_tdata[IW-1:2*VTX_W+WEIGHT_BITS];

endmodule
`default_nettype wire

/* sim/kruskal_edge_filter_union_find_tb.sv */
// Self-checking testbench for the spanning-tree edge filter with a union-find predictor.
module kruskal_edge_filter_union_find_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kefuf_pkg::*;

  localparam int unsigned NV = MAX_VERTICES_DEF;
  localparam int unsigned WB = WEIGHT_BITS_DEF;
  localparam int unsigned IN_W = ((2*VTX_W+WB+1+7)/8)*8;
  localparam int unsigned OUT_W = ((2*VTX_W+WB+CNT_W+3+7)/8)*8;
  // Meaningful result bits of m_axis_tdata (the rest is zero padding).
  localparam int unsigned RES_BITS = 2*VTX_W+WB+CNT_W+3;
  // Hard stop for the whole run; the slowest correct run stays far below it.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Longest edge: two deep find walks, compression and a rank update, with margin.
  localparam int unsigned SETTLE_CYCLES = 150;

  // One edge as it enters the block.
  typedef struct {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dest;
    logic [WB-1:0]    weight;
    logic             new_graph;
    logic             last;
  } edge_t;

  // One filter verdict; the packing matches {tlast, tdata}, members listed from the highest bit down.
  typedef struct packed {
    logic             end_of_graph;
    logic             bad_vertex;
    logic             complete;
    logic [CNT_W-1:0] count;
    logic [WB-1:0]    weight;
    logic [VTX_W-1:0] dest;
    logic [VTX_W-1:0] src;
    logic             taken;
  } verdict_t;

  // Union-find predictor plus the queue of verdicts still owed by the block.
  class mst_scoreboard;
    logic [VTX_W-1:0]  parent [NV];
    logic [RANK_W-1:0] rank_of [NV];
    logic [CNT_W-1:0]  taken_edges;
    int unsigned       vertex_count;
    verdict_t          owed_verdicts[$];
    int unsigned       mismatches;

    function new();
      vertex_count = VC_RESET;
      mismatches = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      for (int v = 0; v < NV; v++) begin
        parent[v] = VTX_W'(v);
        rank_of[v] = '0;
      end
      taken_edges = '0;
    endfunction

    // Walk to the root, then point every node on the path straight at it.
    function int unsigned find_root(int unsigned v);
      int unsigned r;
      int unsigned nxt;
      r = v;
      while (parent[r] != r) r = parent[r];
      while (v != r) begin
        nxt = parent[v];
        parent[v] = VTX_W'(r);
        v = nxt;
      end
      return r;
    endfunction

    // Called on every accepted edge transfer.
    function void note_edge(edge_t e);
      int unsigned eff;
      int unsigned target;
      int unsigned x;
      int unsigned y;
      logic        bad_end;
      logic        take;
      verdict_t    v;
      eff = (vertex_count < NV) ? vertex_count : NV;
      target = (eff > 0) ? eff - 1 : 0;
      take = 1'b0;
      if (e.new_graph) clear_forest();
      bad_end = (e.src >= eff) || (e.dest >= eff);
      // No find at all once the tree is complete or an endpoint is out of range.
      if (!bad_end && taken_edges < target) begin
        x = find_root(e.src);
        y = find_root(e.dest);
        if (x != y) begin
          take = 1'b1;
          taken_edges++;
          if (rank_of[x] < rank_of[y]) begin
            parent[x] = VTX_W'(y);
          end else if (rank_of[x] > rank_of[y]) begin
            parent[y] = VTX_W'(x);
          end else begin
            parent[y] = VTX_W'(x);
            if (rank_of[x] != RANK_MAX) rank_of[x]++;
          end
        end
      end
      v.taken = take;
      v.src = e.src;
      v.dest = e.dest;
      v.weight = e.weight;
      v.count = taken_edges;
      v.complete = (taken_edges >= target);
      v.bad_vertex = bad_end;
      v.end_of_graph = e.last;
      owed_verdicts.push_back(v);
    endfunction

    function string field_note(string name, logic [WB-1:0] want_v, logic [WB-1:0] got_v);
      if (want_v === got_v) return "";
      return $sformatf(" %s expected %0h actual %0h", name, want_v, got_v);
    endfunction

    // Called on every accepted result transfer.
    function void check_result(verdict_t got);
      verdict_t want;
      string    diff;
      diff = "";
      if (owed_verdicts.size() == 0) begin
        diff = $sformatf(" no verdict owed, actual %h", got);
      end else begin
        want = owed_verdicts.pop_front();
        diff = {field_note("taken", want.taken, got.taken),
                field_note("tree_src", want.src, got.src),
                field_note("tree_dest", want.dest, got.dest),
                field_note("tree_weight", want.weight, got.weight),
                field_note("tree_count", want.count, got.count),
                field_note("tree_complete", want.complete, got.complete),
                field_note("bad_vertex", want.bad_vertex, got.bad_vertex),
                field_note("end_of_graph", want.end_of_graph, got.end_of_graph)};
      end
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] verdict mismatch:%s", $time, diff);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [VC_W-1:0]    cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tlast;

  // Percent of cycles in which each side holds off.
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 76;
  int unsigned cycle_count = 0;

  mst_scoreboard scoreboard = new();

  kruskal_edge_filter_union_find DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: decide readiness on the falling edge so it is stable at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor: a transfer happens where tvalid and tready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      scoreboard.check_result(verdict_t'({m_axis_tlast, m_axis_tdata[RES_BITS-1:0]}));
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic edge_t make_edge(int unsigned src, int unsigned dest, int unsigned weight,
                                      bit new_graph, bit last);
    edge_t e;
    e.src = VTX_W'(src);
    e.dest = VTX_W'(dest);
    e.weight = WB'(weight);
    e.new_graph = new_graph;
    e.last = last;
    return e;
  endfunction

  // Offer one edge, starting at a falling edge; return at the falling edge after the transfer.
  task automatic send_edge(edge_t e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = IN_W'({e.new_graph, e.weight, e.dest, e.src});
    s_axis_tlast = e.last;
    do @(posedge clk_i); while (!s_axis_tready);
    scoreboard.note_edge(e);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed verdict, then let the last edge's work settle.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (scoreboard.owed_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_vertex_count(int unsigned value);
    cfg_we_i = 1'b1;
    cfg_wdata_i = VC_W'(value);
    scoreboard.vertex_count = value & ((1 << VC_W) - 1);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random graphs: mostly well-formed (fresh table, sorted weights, last edge marked),
  // with tree-growing edges so that trees actually complete, plus some noise.
  task automatic run_phase(int unsigned budget);
    int unsigned sent;
    int unsigned eff;
    int unsigned n_edges;
    int unsigned grow_vtx;
    int unsigned kind;
    int unsigned a;
    int unsigned b;
    int unsigned w;
    bit          fresh;
    edge_t       e;
    sent = 0;
    while (sent < budget) begin
      eff = (scoreboard.vertex_count < NV) ? scoreboard.vertex_count : NV;
      n_edges = $urandom_range(1, eff + eff / 2 + 2);
      w = $urandom_range(0, 65535 - 8 * n_edges);
      fresh = ($urandom_range(0, 7) != 0);
      grow_vtx = 1;
      for (int i = 0; i < n_edges && sent < budget; i++) begin
        kind = $urandom_range(0, 9);
        w += $urandom_range(0, 8);
        if (kind == 0) begin
          // Noise: any endpoints, any weight, stray flags.
          e = make_edge($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535),
                        $urandom_range(0, 3) == 0, $urandom_range(0, 1));
        end else begin
          if (kind <= 5 && grow_vtx < eff) begin
            // Link the next vertex to one already seen: guarantees progress.
            a = grow_vtx;
            b = $urandom_range(0, grow_vtx - 1);
            grow_vtx++;
          end else begin
            a = $urandom_range(0, eff - 1);
            b = $urandom_range(0, eff - 1);
          end
          if ($urandom_range(0, 1)) e = make_edge(b, a, w, fresh && i == 0, i == n_edges - 1);
          else e = make_edge(a, b, w, fresh && i == 0, i == n_edges - 1);
        end
        send_edge(e);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: eight vertices, build a tree through every union case.
    write_vertex_count(8);
    send_edge(make_edge(0, 1, 0, 1, 0));        // fresh table, first join
    send_edge(make_edge(1, 2, 65535, 0, 0));    // lower rank joins higher
    send_edge(make_edge(2, 0, 65535, 0, 0));    // same component: rejected
    send_edge(make_edge(8, 0, 100, 0, 0));      // source out of range
    send_edge(make_edge(0, 255, 100, 0, 0));    // destination out of range
    send_edge(make_edge(3, 3, 200, 0, 0));      // self loop
    send_edge(make_edge(3, 4, 300, 0, 0));
    send_edge(make_edge(5, 6, 300, 0, 0));
    send_edge(make_edge(4, 6, 400, 0, 0));      // equal ranks: rank grows
    send_edge(make_edge(1, 6, 500, 0, 0));
    send_edge(make_edge(7, 2, 600, 0, 0));      // this edge completes the tree
    send_edge(make_edge(7, 3, 700, 0, 0));      // tree complete: no find
    send_edge(make_edge(7, 0, 800, 0, 1));
    send_edge(make_edge(6, 7, 900, 1, 0));      // new graph resets table and count
    drain();
    // Zero vertices: every edge is bad and the tree reads complete.
    write_vertex_count(0);
    send_edge(make_edge(0, 0, 1, 0, 0));
    drain();
    // One vertex: nothing to take, tree complete from the start.
    write_vertex_count(1);
    send_edge(make_edge(0, 0, 2, 1, 1));
    drain();
    // Above the table size: clamps to the full table.
    write_vertex_count(511);
    send_edge(make_edge(255, 128, 3, 1, 0));
    send_edge(make_edge(128, 255, 4, 0, 0));
    send_edge(make_edge(254, 255, 5, 0, 1));
    drain();
    write_vertex_count(256);
    send_edge(make_edge(170, 85, 16'h5555, 0, 0));
    send_edge(make_edge(85, 170, 16'haaaa, 0, 1));
    drain();

    // Random phases; idling goes sender-light, then receiver-light, then off.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 34;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: write_vertex_count($urandom_range(2, 12));
        1: write_vertex_count(256);
        2: write_vertex_count($urandom_range(2, 40));
        3: write_vertex_count($urandom_range(257, 511));
        4: write_vertex_count($urandom_range(1, 8));
        default: write_vertex_count($urandom_range(9, 100));
      endcase
      run_phase((p == 1) ? 280 : (p == 3) ? 130 : 110);
      drain();
    end

    if (scoreboard.mismatches == 0 && scoreboard.owed_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* kruskal_edge_filter_union_find.f */
design/kefuf_pkg.sv
design/kruskal_edge_filter_union_find.sv
sim/kruskal_edge_filter_union_find_tb.sv
